@@ hdl/mrfd_pkg.sv @@
// Shared types and constants for the mesh relay filter and duplicate suppression block.
// No dependencies; mrfd_ctrl, mrfd_dp and the top level import this package.
package mrfd_pkg;

    localparam int RECENT_DEPTH_DEF = 16;
    localparam int LIST_LENGTH_DEF  = 8;

    localparam int ID_W       = 8;
    localparam int TYPE_W     = 7;
    localparam int LIST_W     = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CACHE_W    = TYPE_W + 2 * ID_W;

    // Message type characters
    localparam logic [TYPE_W-1:0] TYPE_CMD     = 7'h43;  // 'C'
    localparam logic [TYPE_W-1:0] TYPE_KEEP    = 7'h4B;  // 'K'
    localparam logic [TYPE_W-1:0] TYPE_WEATHER = 7'h57;  // 'W'
    localparam logic [TYPE_W-1:0] TYPE_RESP    = 7'h52;  // 'R'
    localparam logic [TYPE_W-1:0] TYPE_PING    = 7'h50;  // 'P'

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_LST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WX_LST  = 2'd2;

    typedef enum logic [2:0] {
        V_UNKNOWN   = 3'd0,
        V_TRUNCATED = 3'd1,
        V_OWN_ECHO  = 3'd2,
        V_NO_RELAY  = 3'd3,
        V_DUPLICATE = 3'd4,
        V_RELAY_FWD = 3'd5,
        V_RELAY_WX  = 3'd6
    } verdict_t;

    typedef struct packed {
        logic [7:0]      header_byte;
        logic [ID_W-1:0] station_id;
        logic [ID_W-1:0] unique_id;
        logic            header_complete;
    } item_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic       deliver_command;
        logic       command_directed;
        logic       relay_demanded;
        logic       check_ping;
        logic       heard_weather;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIST,
        S_CHECK,
        S_SCAN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic list_step;
        logic scan_start;
        logic scan_step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic list_end;
        logic relay_cand;
        logic scan_done;
        logic out_free;
    } ctrl_stat_t;

endpackage

@@ hdl/mrfd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module mrfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/mrfd_ctrl.sv @@
// Sequencing state machine for the relay filter: accept, list scan, cache scan, emit.
// Depends on mrfd_pkg for the state, command and status types.
module mrfd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  mrfd_pkg::ctrl_stat_t stat,
    output mrfd_pkg::ctrl_cmd_t  cmd
);

    import mrfd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LIST;
                end
            end
            S_LIST:
            begin
                cmd.list_step = 1'b1;
                if (stat.list_end)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.relay_cand)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // hold until the output register can take the word
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.list_step, cmd.scan_start, cmd.scan_step, cmd.emit}))
        else $error("more than one datapath command in a cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == S_IDLE))
        else $error("controller did not return to idle after emit");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_LIST))
        else $error("accepted word did not start the list scan");

endmodule

@@ hdl/mrfd_dp.sv @@
// Datapath of the relay filter: config registers, item register, list scan,
// recent-relay cache (RAM ring with fill count) and output register. Uses mrfd_pkg, mrfd_ram.
module mrfd_dp #(
    parameter int RECENT_DEPTH = mrfd_pkg::RECENT_DEPTH_DEF,
    parameter int LIST_LENGTH  = mrfd_pkg::LIST_LENGTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [mrfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mrfd_pkg::LIST_W-1:0]      cfg_data,
    input  mrfd_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output mrfd_pkg::result_t                result,
    input  mrfd_pkg::ctrl_cmd_t              cmd,
    output mrfd_pkg::ctrl_stat_t             stat
);

    import mrfd_pkg::*;

    localparam int IW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
    localparam int CW = $clog2(RECENT_DEPTH + 1);
    localparam int LW = (LIST_LENGTH > 1) ? $clog2(LIST_LENGTH) : 1;
    localparam logic [CW-1:0] DEPTH_C    = CW'(RECENT_DEPTH);
    localparam logic [IW-1:0] LAST_PTR   = IW'(RECENT_DEPTH - 1);
    localparam logic [LW-1:0] LAST_LIDX  = LW'(LIST_LENGTH - 1);

    // configuration
    logic [ID_W-1:0]   own_id_reg;
    logic [LIST_W-1:0] cmd_list_reg;
    logic [LIST_W-1:0] wx_list_reg;

    // item and scan state
    item_t             item_reg;
    logic              listed_reg,   listed_next;
    logic [LW-1:0]     list_idx_reg, list_idx_next;
    logic [CW-1:0]     scan_cnt_reg, scan_cnt_next;
    logic              cmp_vld_reg,  cmp_vld_next;
    logic              hit_reg,      hit_next;
    logic [CW-1:0]     fill_reg,     fill_next;
    logic [IW-1:0]     wr_ptr_reg,   wr_ptr_next;
    result_t           result_reg;
    logic              result_valid_reg, result_valid_next;

    logic [TYPE_W-1:0]  msg_type;
    logic               known;
    logic               own_hit;
    logic               own_echo;
    logic               list_applies;
    logic [LIST_W-1:0]  list_sel;
    logic [ID_W-1:0]    list_byte;
    logic               relay_cand;
    logic               push;
    logic [CACHE_W-1:0] cache_key;
    logic [CACHE_W-1:0] rd_data;
    logic               issue;
    logic               list_end;
    logic               scan_done;
    logic               out_free;
    result_t            result_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg   <= '0;
            cmd_list_reg <= '0;
            wx_list_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_OWN_ID:  own_id_reg   <= cfg_data[ID_W-1:0];
                CFG_CMD_LST: cmd_list_reg <= cfg_data;
                CFG_WX_LST:  wx_list_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.emit)
        begin
            result_reg <= result_new;
        end
    end

    // classification of the held item
    always_comb
    begin
        msg_type     = item_reg.header_byte[TYPE_W-1:0];
        known        = msg_type inside {TYPE_CMD, TYPE_KEEP, TYPE_WEATHER, TYPE_RESP, TYPE_PING};
        own_hit      = (item_reg.station_id == own_id_reg);
        own_echo     = (msg_type != TYPE_CMD) && own_hit;
        list_applies = known && item_reg.header_complete && !own_hit
                       && !item_reg.header_byte[7] && (msg_type != TYPE_PING);
        list_sel     = (msg_type == TYPE_WEATHER) ? wx_list_reg : cmd_list_reg;
        list_byte    = list_sel[{list_idx_reg, 3'b000} +: ID_W];
        relay_cand   = known && item_reg.header_complete && !own_hit
                       && (item_reg.header_byte[7] || listed_reg);
        cache_key    = {msg_type, item_reg.station_id, item_reg.unique_id};
        issue        = (scan_cnt_reg != fill_reg);
        push         = cmd.emit && relay_cand && !hit_reg;
    end

    // list scan: one id byte per cycle, a zero byte ends the list
    always_comb
    begin
        listed_next   = listed_reg;
        list_idx_next = list_idx_reg;
        list_end      = !list_applies || (list_byte == '0)
                        || (list_byte == item_reg.station_id) || (list_idx_reg == LAST_LIDX);
        if (cmd.load)
        begin
            listed_next   = 1'b0;
            list_idx_next = '0;
        end
        else if (cmd.list_step)
        begin
            if (list_applies && (list_byte != '0) && (list_byte == item_reg.station_id))
            begin
                listed_next = 1'b1;
            end
            if (!list_end)
            begin
                list_idx_next = list_idx_reg + 1'b1;
            end
        end
    end

    // cache scan: address issued one cycle, compared the next
    always_comb
    begin
        scan_cnt_next = scan_cnt_reg;
        cmp_vld_next  = 1'b0;
        hit_next      = hit_reg;
        if (cmd.scan_start)
        begin
            scan_cnt_next = '0;
            hit_next      = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (issue && !hit_reg)
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                cmp_vld_next  = 1'b1;
            end
            if (cmp_vld_reg && (rd_data == cache_key))
            begin
                hit_next = 1'b1;
            end
        end
        scan_done = hit_reg || (!issue && !cmp_vld_reg);
    end

    // ring write pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (fill_reg != DEPTH_C)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        result_new                 = '0;
        result_new.relay_demanded  = item_reg.header_byte[7];
        if (!known)
        begin
            result_new.verdict = V_UNKNOWN;
        end
        else if (!item_reg.header_complete)
        begin
            result_new.verdict = V_TRUNCATED;
        end
        else
        begin
            result_new.check_ping = (msg_type == TYPE_PING);
            if (own_echo)
            begin
                result_new.verdict = V_OWN_ECHO;
            end
            else
            begin
                result_new.deliver_command  = (msg_type == TYPE_CMD)
                                              && (own_hit || (item_reg.station_id == '0));
                result_new.command_directed = result_new.deliver_command
                                              && (item_reg.station_id != '0);
                result_new.heard_weather    = (msg_type == TYPE_WEATHER);
                if (!relay_cand)
                begin
                    result_new.verdict = V_NO_RELAY;
                end
                else if (hit_reg)
                begin
                    result_new.verdict = V_DUPLICATE;
                end
                else if (msg_type == TYPE_WEATHER)
                begin
                    result_new.verdict = V_RELAY_WX;
                end
                else
                begin
                    result_new.verdict = V_RELAY_FWD;
                end
            end
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        out_free = !result_valid_reg || !result_stall;
    end

    always_comb
    begin
        stat.list_end   = list_end;
        stat.relay_cand = relay_cand;
        stat.scan_done  = scan_done;
        stat.out_free   = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listed_reg       <= 1'b0;
            list_idx_reg     <= '0;
            scan_cnt_reg     <= '0;
            cmp_vld_reg      <= 1'b0;
            hit_reg          <= 1'b0;
            fill_reg         <= '0;
            wr_ptr_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            listed_reg       <= listed_next;
            list_idx_reg     <= list_idx_next;
            scan_cnt_reg     <= scan_cnt_next;
            cmp_vld_reg      <= cmp_vld_next;
            hit_reg          <= hit_next;
            fill_reg         <= fill_next;
            wr_ptr_reg       <= wr_ptr_next;
            result_valid_reg <= result_valid_next;
        end
    end

    mrfd_ram #(
        .WIDTH (CACHE_W),
        .DEPTH (RECENT_DEPTH)
    ) u_cache (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (wr_ptr_reg),
        .wr_data (cache_key),
        .rd_addr (scan_cnt_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_C)
        else $error("cache fill count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != DEPTH_C) |-> (wr_ptr_reg == fill_reg[IW-1:0]))
        else $error("write pointer out of step with fill count");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result word overwritten before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && relay_cand && hit_reg) |-> (fill_reg != '0))
        else $error("duplicate reported with an empty cache");

endmodule

@@ hdl/mesh_relay_filter_dedup_unit.sv @@
// Top level of the mesh relay filter with duplicate suppression.
// Depends on mrfd_pkg, mrfd_ctrl, mrfd_dp (which holds mrfd_ram).
//
// One header word in, one verdict word out. After a word is accepted, the block
// walks the relay list one byte per cycle until the station is found, a zero
// byte ends the list or the last entry is reached; then, for a relay candidate,
// it reads the recent-relay cache RAM once per stored entry and compares each
// registered read with the key, stopping at the first match. The block takes one
// word at a time; a finished verdict waits in the output register while the next
// header is accepted. The cache starts empty after reset through its fill
// count, so no clearing pass is needed.
// Configuration must be written only while the block is idle; it is not enforced.
module mesh_relay_filter_dedup_unit #(
    parameter int RECENT_DEPTH = mrfd_pkg::RECENT_DEPTH_DEF,
    parameter int LIST_LENGTH  = mrfd_pkg::LIST_LENGTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [mrfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mrfd_pkg::LIST_W-1:0]    cfg_data,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  mrfd_pkg::item_t                item,
    output logic                           result_valid,
    input  logic                           result_stall,
    output mrfd_pkg::result_t              result
);

    import mrfd_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    mrfd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    mrfd_dp #(
        .RECENT_DEPTH (RECENT_DEPTH),
        .LIST_LENGTH  (LIST_LENGTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule
